[hw/rtl/sftd_pkg.sv]
// shared types for the smallest-factor trial division block
// used by sftd_div and smallest_factor_trial_division
package sftd_pkg;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } sftd_state_e;

  // request from the sequencer to the divider
  typedef struct packed {
    logic start;
  } sftd_div_ctrl_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } sftd_div_stat_t;

endpackage

[hw/rtl/smallest_factor_trial_division.sv]
// smallest factor of an unsigned number by trial division with divisors 2, 3, ...
// top level: sequencer around one shared serial divider (sftd_div), uses sftd_pkg
//
// channel   dir  tdata                        tuser
// s_axis    in   [WIDTH-1:0] number           -
// m_axis    out  [WIDTH-1:0] factor           [0] divisor_found
//
// each trial divisor d runs WIDTH steps in the serial divider, which gives n/d
// and n%d at once; a 31-bit prime takes up to 46340 trials.
// s_axis_tready_o is high only while idle; one item is worked at a time.
// the result sits in an output register; a stalled m_axis holds the next
// result in the sequencer until the register frees up.
// reset is asynchronous, active low, and clears control state only.
module smallest_factor_trial_division #(
  parameter int unsigned WIDTH = 31
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [((WIDTH+7)/8)*8-1:0]    s_axis_tdata_i,  // [WIDTH-1:0] number
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [((WIDTH+7)/8)*8-1:0]    m_axis_tdata_o,  // [WIDTH-1:0] factor
  output logic                          m_axis_tuser_o   // [0] divisor_found
);
  import sftd_pkg::*;

  localparam int unsigned DataW = ((WIDTH + 7) / 8) * 8;

  sftd_state_e      state_q, state_d;
  logic [WIDTH-1:0] num_q, num_d;
  logic [WIDTH-1:0] trial_q, trial_d;
  logic [WIDTH-1:0] res_q, res_d;
  logic             res_found_q, res_found_d;
  logic [WIDTH-1:0] factor_q, factor_d;
  logic             found_q, found_d;
  logic             out_valid_q, out_valid_d;

  sftd_div_ctrl_t   div_ctrl;
  sftd_div_stat_t   div_stat;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] rem;
  logic             out_free;

  // divider loads its operands on start, so it takes the next values
  sftd_div #(
    .WIDTH (WIDTH)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (div_ctrl),
    .dividend_i  (num_d),
    .divisor_i   (trial_d),
    .stat_o      (div_stat),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  assign out_free = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q       <= num_d;
    trial_q     <= trial_d;
    res_q       <= res_d;
    res_found_q <= res_found_d;
    factor_q    <= factor_d;
    found_q     <= found_d;
  end

  always_comb begin
    state_d        = state_q;
    num_d          = num_q;
    trial_d        = trial_q;
    res_d          = res_q;
    res_found_d    = res_found_q;
    factor_d       = factor_q;
    found_d        = found_q;
    out_valid_d    = out_valid_q && !m_axis_tready_i;
    div_ctrl.start = 1'b0;
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          num_d          = s_axis_tdata_i[WIDTH-1:0];
          trial_d        = WIDTH'(2);
          div_ctrl.start = 1'b1;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          // loop runs while d <= n/d, checked before the remainder
          priority if (trial_q > quo) begin
            res_d       = num_q;
            res_found_d = 1'b0;
            state_d     = S_DONE;
          end else if (rem == '0) begin
            res_d       = trial_q;
            res_found_d = 1'b1;
            state_d     = S_DONE;
          end else begin
            trial_d        = trial_q + WIDTH'(1);
            div_ctrl.start = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          factor_d    = res_q;
          found_d     = res_found_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = DataW'(factor_q);
  assign m_axis_tuser_o  = found_q;

  a_found_is_proper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && found_q) |-> (factor_q >= WIDTH'(2)))
    else $error("reported divisor below two");

  a_done_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == S_DIV))
    else $error("divider finished outside a trial");

  a_trial_at_least_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (trial_q >= WIDTH'(2)))
    else $error("trial divisor below two");

  a_idle_divider_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !div_stat.busy)
    else $error("divider busy while idle");

endmodule

[hw/rtl/sftd_div.sv]
// restoring serial divider, one quotient bit per cycle
// depends on sftd_pkg for the control and status structs
module sftd_div #(
  parameter int unsigned WIDTH = 31
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sftd_pkg::sftd_div_ctrl_t ctrl_i,
  input  logic [WIDTH-1:0]        dividend_i,
  input  logic [WIDTH-1:0]        divisor_i,
  output sftd_pkg::sftd_div_stat_t stat_o,
  output logic [WIDTH-1:0]        quotient_o,
  output logic [WIDTH-1:0]        remainder_o
);
  import sftd_pkg::*;

  localparam int unsigned CntW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH-1:0] dvs_q, dvs_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             fits;

  assign shifted = {rem_q, quo_q[WIDTH-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = (shifted >= {1'b0, dvs_q});

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = CntW'(WIDTH);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the top bit of diff drops
      rem_d = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
      quo_d = {quo_q[WIDTH-2:0], fits};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done_q;
  assign quotient_o   = quo_q;
  assign remainder_o  = rem_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < dvs_q))
    else $error("remainder not below divisor");

  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q || $past(ctrl_i.start))
    else $error("divider busy in the cycle after finishing");

  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != '0))
    else $error("divider busy with zero step count");

endmodule
